### sv/cidr_rbm_pkg.sv
// Shared types and codes for the CIDR range table block.
package cidr_rbm_pkg;

    // Item modes.
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DUP     = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } t_state;

    // One stored range, inclusive bounds.
    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
    } t_range;

    // Outcome of comparing the current item against one stored range.
    typedef struct packed {
        logic eq;
        logic in_rng;
    } t_cmp_res;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PLEN_W  = 6;
    localparam int unsigned COUNT_W = 9;
    localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

endpackage

### sv/cidr_rbm_mem.sv
// Range table storage: one write port and one registered read port.
module cidr_rbm_mem
    import cidr_rbm_pkg::*;
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_range        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_range        o_rd_data
);

    t_range r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### sv/cidr_rbm_cmp.sv
// Shared compare unit: matches the current item against one stored range.
module cidr_rbm_cmp
    import cidr_rbm_pkg::*;
(
    input  t_range   i_key,
    input  t_range   i_entry,
    output t_cmp_res o_res
);

    // Exact match of both bounds for duplicate detection on insert.
    assign o_res.eq = (i_key.lo == i_entry.lo) && (i_key.hi == i_entry.hi);

    // Inclusive containment of the query address, held in the key's low bound.
    assign o_res.in_rng = (i_key.lo >= i_entry.lo) && (i_key.lo <= i_entry.hi);

endmodule

### sv/cidr_range_blacklist_match_top.sv
// Top level of the IPv4 CIDR range table with clear, insert, lookup and hit counting.
//
// Usage: an item (i_mode, i_address, i_prefix_len) is transferred at a rising
// edge where start is high and busy is low. Busy stays high until the item's
// result is registered. Every item gives exactly one result, shown on
// o_status, o_hit, o_entry_count and o_hit_total for one cycle while o_valid
// is high; the receiver cannot stall it, and a new item may be started in the
// same cycle that the result is shown.
// Clear, unused mode and an insert with a bad prefix length go straight to the
// result state. Insert and lookup scan the stored ranges one per cycle through a
// single table read port and one shared compare unit; a hit stops the scan early.
// Reset empties the table and zeroes the hit counter; the table contents are
// not cleared, as only entries below the count are ever read.
module cidr_range_blacklist_match_top
    import cidr_rbm_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_mode,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [PLEN_W-1:0]     i_prefix_len,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic                  o_hit,
    output logic [COUNT_W-1:0]    o_entry_count,
    output logic [ADDR_W-1:0]     o_hit_total
);

    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    t_state         r_state, n_state;
    t_mode          r_mode;
    t_range         r_key;
    logic           r_invalid;
    logic           r_match, n_match;
    logic           r_pend, n_pend;
    logic [CW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_count, n_count;
    logic [31:0]    r_hits, n_hits;

    logic           n_valid;
    t_status        n_status;
    logic           n_hit;

    logic           issue;
    logic           cmp_hit;
    logic           accept;
    logic           wr_en;
    logic [31:0]    mask;
    t_range         rd_data;
    t_cmp_res       cmp_res;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign issue  = (r_idx < r_count);
    assign mask   = 32'hFFFF_FFFF >> i_prefix_len;

    // Compare result that ends the scan for the current mode.
    assign cmp_hit = (r_mode == MODE_INSERT) ? cmp_res.eq : cmp_res.in_rng;

    cidr_rbm_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (issue && (r_state == S_SCAN)),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    cidr_rbm_cmp u_cmp (
        .i_key   (r_key),
        .i_entry (rd_data),
        .o_res   (cmp_res)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_mode == MODE_LOOKUP) ||
                        ((i_mode == MODE_INSERT) && (i_prefix_len != '0) &&
                         (i_prefix_len <= PLEN_MAX))) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if ((r_pend && cmp_hit) || (!issue && !r_pend)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and result logic of the sequencer.
    always_comb begin
        n_match  = r_match;
        n_pend   = 1'b0;
        n_idx    = r_idx;
        n_count  = r_count;
        n_hits   = r_hits;
        n_valid  = 1'b0;
        n_status = ST_OK;
        n_hit    = 1'b0;
        wr_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_match = 1'b0;
                n_idx   = '0;
            end
            S_SCAN: begin
                if (issue) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend && cmp_hit) begin
                    n_match = 1'b1;
                end
            end
            S_FINISH: begin
                n_valid = 1'b1;
                case (r_mode)
                    MODE_CLEAR: begin
                        n_count = '0;
                    end
                    MODE_INSERT: begin
                        if (r_invalid) begin
                            n_status = ST_INVALID;
                        end else if (r_match) begin
                            n_status = ST_DUP;
                        end else if (r_count >= MAX_CNT) begin
                            n_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                    MODE_LOOKUP: begin
                        if (r_match) begin
                            n_hit  = 1'b1;
                            n_hits = r_hits + 32'd1;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            default: begin
                n_match = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hits  <= '0;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hits  <= n_hits;
            r_pend  <= n_pend;
            o_valid <= n_valid;
        end
    end

    // Item and scan registers.
    always_ff @(posedge i_clk) begin
        r_match <= n_match;
        r_idx   <= n_idx;
        if (accept) begin
            r_mode    <= t_mode'(i_mode);
            r_key.lo  <= i_address;
            r_key.hi  <= i_address + mask;
            r_invalid <= (i_prefix_len == '0) || (i_prefix_len > PLEN_MAX);
        end
    end

    // Result registers; the counts reflect the state after the item.
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            o_status      <= n_status;
            o_hit         <= n_hit;
            o_entry_count <= COUNT_W'(n_count);
            o_hit_total   <= n_hits;
        end
    end

endmodule

### dv/cidr_range_blacklist_match_top_test.sv
// Self-checking testbench for the CIDR range table: random and directed items, scoreboard check.
module cidr_range_blacklist_match_top_test
    import cidr_rbm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TBL_DEPTH   = 256;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_WAIT  = TBL_DEPTH + 40;
    localparam int unsigned PRINT_CAP   = 100;

    // One command as sent to the block.
    typedef struct packed {
        t_mode              op;
        logic [ADDR_W-1:0]  addr;
        logic [PLEN_W-1:0]  plen;
    } t_range_cmd;

    // Result that the table is expected to report for one command.
    typedef struct packed {
        t_status            status;
        logic               hit;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  total;
    } t_table_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic [1:0]          i_mode = MODE_NONE;
    logic [ADDR_W-1:0]   i_address = '0;
    logic [PLEN_W-1:0]   i_prefix_len = '0;
    logic                busy;
    logic                o_valid;
    logic [1:0]          o_status;
    logic                o_hit;
    logic [COUNT_W-1:0]  o_entry_count;
    logic [ADDR_W-1:0]   o_hit_total;

    // Commands waiting to be sent, and replies waiting to come back.
    t_range_cmd          cmd_q[$];
    t_table_reply        reply_q[$];
    t_range_cmd          next_cmd;
    t_table_reply        want;
    bit                  took_cmd = 1'b0;
    int unsigned         idle_pct = 0;
    int unsigned         cycle_count = 0;
    int unsigned         mismatches = 0;

    // Shadow of the range table as the block should hold it.
    logic [ADDR_W-1:0]   tbl_lo [TBL_DEPTH];
    logic [ADDR_W-1:0]   tbl_hi [TBL_DEPTH];
    int unsigned         tbl_count = 0;
    logic [ADDR_W-1:0]   hit_count = '0;

    // Ranges the stimulus has inserted so far, used to aim lookups and duplicates.
    logic [ADDR_W-1:0]   gen_lo[$];
    logic [PLEN_W-1:0]   gen_plen[$];

    cidr_range_blacklist_match_top #(
        .MAX_ENTRIES   (TBL_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_address     (i_address),
        .i_prefix_len  (i_prefix_len),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_hit         (o_hit),
        .o_entry_count (o_entry_count),
        .o_hit_total   (o_hit_total)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Applies one command to the shadow table and returns the reply it should give.
    function automatic t_table_reply predict_table_reply(t_mode op, logic [ADDR_W-1:0] addr,
                                                         logic [PLEN_W-1:0] plen);
        t_table_reply      r;
        logic [63:0]       span;
        logic [ADDR_W-1:0] upper;
        bit                dup;
        r.status = ST_OK;
        r.hit    = 1'b0;
        case (op)
            MODE_CLEAR: begin
                tbl_count = 0;
            end
            MODE_INSERT: begin
                if (plen == '0 || plen > PLEN_MAX) begin
                    r.status = ST_INVALID;
                end else begin
                    span  = (64'd1 << (ADDR_W - plen)) - 64'd1;
                    upper = addr + span[ADDR_W-1:0];
                    dup   = 1'b0;
                    for (int unsigned i = 0; i < tbl_count; i++) begin
                        if (tbl_lo[i] == addr && tbl_hi[i] == upper) begin
                            dup = 1'b1;
                        end
                    end
                    if (dup) begin
                        r.status = ST_DUP;
                    end else if (tbl_count >= TBL_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl_lo[tbl_count] = addr;
                        tbl_hi[tbl_count] = upper;
                        tbl_count++;
                    end
                end
            end
            MODE_LOOKUP: begin
                // A wrapped range has lo above hi and so can never match.
                for (int unsigned i = 0; i < tbl_count && !r.hit; i++) begin
                    if (addr >= tbl_lo[i] && addr <= tbl_hi[i]) begin
                        r.hit = 1'b1;
                    end
                end
                if (r.hit) begin
                    hit_count = hit_count + 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count = tbl_count[COUNT_W-1:0];
        r.total = hit_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    // Queues a command and keeps track of the ranges it should have added.
    task automatic push_cmd(input t_mode op, input logic [ADDR_W-1:0] addr,
                            input logic [PLEN_W-1:0] plen);
        t_range_cmd c;
        c.op   = op;
        c.addr = addr;
        c.plen = plen;
        cmd_q.push_back(c);
        if (op == MODE_CLEAR) begin
            gen_lo.delete();
            gen_plen.delete();
        end else if (op == MODE_INSERT && plen != '0 && plen <= PLEN_MAX) begin
            gen_lo.push_back(addr);
            gen_plen.push_back(plen);
        end
    endtask

    // Mostly valid prefix lengths, biased toward narrow ranges, with some bad ones.
    function automatic logic [PLEN_W-1:0] pick_plen();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            return $urandom_range(1) ? 6'd0 : 6'($urandom_range(63, 33));
        end else if (sel < 5) begin
            return 6'($urandom_range(32, 20));
        end
        return 6'($urandom_range(32, 1));
    endfunction

    // An address on, just outside, or inside one of the inserted ranges.
    function automatic logic [ADDR_W-1:0] near_address();
        int unsigned       k;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [63:0]       span;
        k    = $urandom_range(gen_lo.size() - 1);
        lo   = gen_lo[k];
        span = (64'd1 << (ADDR_W - gen_plen[k])) - 64'd1;
        hi   = lo + span[ADDR_W-1:0];
        case ($urandom_range(4))
            0:       return lo;
            1:       return hi;
            2:       return lo - 1'b1;
            3:       return hi + 1'b1;
            default: return lo + (span[ADDR_W-1:0] & $urandom());
        endcase
    endfunction

    // One random command: mostly inserts and aimed lookups, with clears and noise.
    task automatic push_random_cmd();
        int unsigned sel;
        int unsigned k;
        sel = $urandom_range(99);
        if (sel < 3) begin
            push_cmd(MODE_CLEAR, $urandom(), 6'($urandom_range(63)));
        end else if (sel < 6) begin
            push_cmd(MODE_NONE, $urandom(), 6'($urandom_range(63)));
        end else if (sel < 50) begin
            if (gen_lo.size() != 0 && $urandom_range(9) == 0) begin
                k = $urandom_range(gen_lo.size() - 1);
                push_cmd(MODE_INSERT, gen_lo[k], gen_plen[k]);
            end else begin
                push_cmd(MODE_INSERT, $urandom(), pick_plen());
            end
        end else if (gen_lo.size() != 0 && $urandom_range(9) < 6) begin
            push_cmd(MODE_LOOKUP, near_address(), 6'($urandom_range(63)));
        end else begin
            push_cmd(MODE_LOOKUP, $urandom(), 6'($urandom_range(63)));
        end
    endtask

    // Driver: holds a command until it is transferred, idles at random in between.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_cmd) begin
            took_cmd = 1'b0;
            if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_cmd = cmd_q.pop_front();
                start        <= 1'b1;
                i_mode       <= next_cmd.op;
                i_address    <= next_cmd.addr;
                i_prefix_len <= next_cmd.plen;
            end else begin
                // Junk on the fields while start is low must be ignored.
                start        <= 1'b0;
                i_mode       <= 2'($urandom());
                i_address    <= $urandom();
                i_prefix_len <= 6'($urandom());
            end
        end
    end

    // Monitor: predicts on each transfer and checks each result strobe.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (o_valid) begin
                if (reply_q.size() == 0) begin
                    report_mismatch("result strobe with no command outstanding");
                end else begin
                    want = reply_q.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    end
                    if (o_hit !== want.hit) begin
                        report_mismatch($sformatf("hit %0d, expected %0d", o_hit, want.hit));
                    end
                    if (o_entry_count !== want.count) begin
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  o_entry_count, want.count));
                    end
                    if (o_hit_total !== want.total) begin
                        report_mismatch($sformatf("hit_total %0d, expected %0d",
                                                  o_hit_total, want.total));
                    end
                end
            end
            if (start && !busy) begin
                reply_q.push_back(predict_table_reply(t_mode'(i_mode), i_address,
                                                      i_prefix_len));
                took_cmd = 1'b1;
            end
        end
    end

    // Stimulus: reset, directed cases, then three random phases with different idling.
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender skips a chance to send with a probability of 14 percent.
        idle_pct = 14;
        push_cmd(MODE_LOOKUP, 32'h0000_0000, 6'd0);            // lookup on an empty table
        push_cmd(MODE_INSERT, 32'h0000_0000, 6'd1);            // widest valid range
        push_cmd(MODE_INSERT, 32'h0000_0000, 6'd1);            // duplicate of it
        push_cmd(MODE_INSERT, 32'h0a00_0000, 6'd0);            // prefix length zero
        push_cmd(MODE_INSERT, 32'h0a00_0000, 6'd33);           // prefix just above 32
        push_cmd(MODE_INSERT, 32'hffff_ffff, 6'd63);           // largest prefix value
        push_cmd(MODE_INSERT, 32'hffff_ffff, 6'd32);           // single top address
        push_cmd(MODE_INSERT, 32'hffff_ff00, 6'd1);            // upper bound wraps
        push_cmd(MODE_LOOKUP, 32'h0000_0000, 6'd63);           // lower edge of a range
        push_cmd(MODE_LOOKUP, 32'h7fff_ffff, 6'd0);            // upper edge of a range
        push_cmd(MODE_LOOKUP, 32'h8000_0000, 6'd0);            // no stored range covers it
        push_cmd(MODE_LOOKUP, 32'hffff_ffff, 6'd0);
        push_cmd(MODE_LOOKUP, 32'hffff_fffe, 6'd0);
        push_cmd(MODE_NONE, 32'h5a5a_a5a5, 6'd21);
        push_cmd(MODE_INSERT, 32'h1234_5678, 6'd32);
        push_cmd(MODE_LOOKUP, 32'h1234_5678, 6'd32);
        push_cmd(MODE_CLEAR, 32'hffff_ffff, 6'd63);            // empties table, keeps hit total
        push_cmd(MODE_LOOKUP, 32'h0000_0000, 6'd0);
        push_cmd(MODE_INSERT, 32'h8000_0000, 6'd1);            // reaches the top without wrapping
        push_cmd(MODE_LOOKUP, 32'hffff_ffff, 6'd0);
        push_cmd(MODE_INSERT, 32'h8000_0001, 6'd1);            // upper bound wraps to zero
        push_cmd(MODE_NONE, 32'hffff_ffff, 6'd63);
        repeat (180) push_random_cmd();
        while (cmd_q.size() != 0 || start) @(posedge i_clk);

        // Phase two: sender skips a chance to send with a probability of 62 percent.
        idle_pct = 62;
        repeat (200) push_random_cmd();
        while (cmd_q.size() != 0 || start) @(posedge i_clk);

        // Phase three, no idling: fill the table, then hit it while full.
        idle_pct = 0;
        push_cmd(MODE_CLEAR, 32'h0, 6'd0);
        repeat (TBL_DEPTH) push_cmd(MODE_INSERT, $urandom(), 6'($urandom_range(32, 1)));
        for (int unsigned k = 0; k < 6; k++) begin
            push_cmd(MODE_INSERT, gen_lo[k], gen_plen[k]);     // duplicate beats full
        end
        push_cmd(MODE_INSERT, $urandom(), 6'($urandom_range(32, 1)));
        push_cmd(MODE_INSERT, $urandom(), 6'd0);
        repeat (30) push_random_cmd();
        while (cmd_q.size() != 0 || start) @(posedge i_clk);

        // Drain the outstanding results, then allow for a full-table scan.
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
